[rtl/rpg_pkg.sv]
// shared constants and types of the rainbow pattern generator
`default_nettype none

package rpg_pkg;

    localparam int NUM_LEDS_DEF = 32;

    localparam int IDX_W   = 6;
    localparam int COLOR_W = 8;
    localparam int SPAN_W  = 10;
    localparam int STEP_W  = 11;

    // scaled index is led index times 256
    localparam int DIVIDEND_W = IDX_W + COLOR_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam logic [SPAN_W-1:0]  SPAN_RESET = SPAN_W'(32);
    localparam logic [STEP_W-1:0]  STEP_WRAP  = STEP_W'(256 * 5);
    localparam logic [COLOR_W-1:0] COLOR_MAX  = 8'hFF;
    localparam logic [COLOR_W-1:0] SEG_ONE    = COLOR_W'(85);
    localparam logic [COLOR_W-1:0] SEG_TWO    = COLOR_W'(170);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

[rtl/rpg_if.sv]
// valid/ready channels of the rainbow pattern generator
`default_nettype none

interface rpg_in_if;
    logic valid;
    logic ready;
    logic frame_tick;

    modport source (output valid, output frame_tick, input ready);
    modport sink   (input valid, input frame_tick, output ready);
endinterface

interface rpg_out_if;
    logic                         valid;
    logic                         ready;
    logic [rpg_pkg::IDX_W-1:0]    led_index;
    logic [rpg_pkg::COLOR_W-1:0]  red;
    logic [rpg_pkg::COLOR_W-1:0]  green;
    logic [rpg_pkg::COLOR_W-1:0]  blue;
    logic                         frame_end;

    modport source (output valid, output led_index, output red, output green,
                    output blue, output frame_end, input ready);
    modport sink   (input valid, input led_index, input red, input green,
                    input blue, input frame_end, output ready);
endinterface

`default_nettype wire

[rtl/rpg_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module rpg_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [rpg_pkg::DIVIDEND_W-1:0]    i_dividend,
    input  wire logic [rpg_pkg::SPAN_W-1:0]        i_divisor,
    output logic                                   o_done,
    output logic [rpg_pkg::COLOR_W-1:0]            o_quot
);

    localparam logic [rpg_pkg::DIV_CNT_W-1:0] LastCnt =
        rpg_pkg::DIV_CNT_W'(rpg_pkg::DIVIDEND_W - 1);

    // dividend bits leave at the top, quotient bits enter at the bottom
    logic [rpg_pkg::DIVIDEND_W-1:0] r_num;
    logic [rpg_pkg::SPAN_W-1:0]     r_rem;
    logic [rpg_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                           r_busy;
    logic                           r_done;

    logic [rpg_pkg::SPAN_W:0]       trial;
    logic [rpg_pkg::SPAN_W+1:0]     diff;
    logic                           fits;
    logic [rpg_pkg::SPAN_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_num[rpg_pkg::DIVIDEND_W-1]};
        diff  = {1'b0, trial} - {2'b00, i_divisor};
        fits  = !diff[rpg_pkg::SPAN_W+1];
        // a zero divisor always fits, so the quotient saturates to all ones
        n_rem = fits ? diff[rpg_pkg::SPAN_W-1:0] : trial[rpg_pkg::SPAN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LastCnt) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[rpg_pkg::DIVIDEND_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num[rpg_pkg::COLOR_W-1:0];

endmodule

`default_nettype wire

[rtl/rpg_wheel.sv]
// color wheel: wheel position to red, green and blue ramps
`default_nettype none

module rpg_wheel (
    input  wire logic [rpg_pkg::COLOR_W-1:0] i_pos,
    output logic      [rpg_pkg::COLOR_W-1:0] o_red,
    output logic      [rpg_pkg::COLOR_W-1:0] o_green,
    output logic      [rpg_pkg::COLOR_W-1:0] o_blue
);

    logic [rpg_pkg::COLOR_W-1:0] inv;
    logic [rpg_pkg::COLOR_W-1:0] seg;
    logic [rpg_pkg::COLOR_W-1:0] up;
    logic [rpg_pkg::COLOR_W-1:0] down;

    always_comb begin
        inv = rpg_pkg::COLOR_MAX - i_pos;
        if (inv < rpg_pkg::SEG_ONE) begin
            seg = inv;
        end else if (inv < rpg_pkg::SEG_TWO) begin
            seg = inv - rpg_pkg::SEG_ONE;
        end else begin
            seg = inv - rpg_pkg::SEG_TWO;
        end
        // seg is at most 85, so three times it still fits in a byte
        up   = {seg[rpg_pkg::COLOR_W-2:0], 1'b0} + seg;
        down = rpg_pkg::COLOR_MAX - up;

        if (inv < rpg_pkg::SEG_ONE) begin
            o_red   = down;
            o_green = '0;
            o_blue  = up;
        end else if (inv < rpg_pkg::SEG_TWO) begin
            o_red   = '0;
            o_green = up;
            o_blue  = down;
        end else begin
            o_red   = up;
            o_green = down;
            o_blue  = '0;
        end
    end

endmodule

`default_nettype wire

[rtl/rainbow_pattern_generator.sv]
// top level of the rainbow pattern generator: frame sequencer and output register
//
// Usage:
//   i_in is a valid/ready sink of one-bit frame_tick words. A word with
//   frame_tick 0 is taken and dropped. A word with frame_tick 1 advances the
//   phase step (0..1279, wrapping) and starts a frame of NUM_LEDS color words
//   on o_out, led index 0 first; the last word carries frame_end.
//   i_cfg_we/i_cfg_data write effect_span; write it only while no frame runs.
//   Each color needs one pass of the bit-serial divider over the 14 dividend
//   bits, one quotient bit per cycle; the next division starts only when the
//   previous word was taken, so the words of a frame are computed one at a
//   time, with no overlap. i_in is ready only between frames.
//   A stalled receiver holds the current word in the output register; the
//   divider waits for it to be taken and nothing is dropped.
//   Reset (synchronous, active low) clears the phase step, sets effect_span
//   to 32 and abandons any frame in progress.
`default_nettype none

module rainbow_pattern_generator #(
    parameter int NUM_LEDS = rpg_pkg::NUM_LEDS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    rpg_in_if.sink                           i_in,
    rpg_out_if.source                        o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [rpg_pkg::SPAN_W-1:0]  i_cfg_data
);

    localparam logic [rpg_pkg::IDX_W-1:0] LastIdx = rpg_pkg::IDX_W'(NUM_LEDS - 1);

    rpg_pkg::t_state r_state, n_state;

    logic [rpg_pkg::SPAN_W-1:0]   r_span;
    logic [rpg_pkg::STEP_W-1:0]   r_step, n_step;
    logic [rpg_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic                         r_out_valid, n_out_valid;
    logic [rpg_pkg::IDX_W-1:0]    r_out_idx;
    logic [rpg_pkg::COLOR_W-1:0]  r_red, r_green, r_blue;
    logic                         r_frame_end;

    logic                         div_start;
    logic                         div_done;
    logic [rpg_pkg::COLOR_W-1:0]  div_quot;
    logic [rpg_pkg::STEP_W-1:0]   step_inc;
    logic [rpg_pkg::COLOR_W-1:0]  hue_pos;
    logic [rpg_pkg::COLOR_W-1:0]  wheel_red, wheel_green, wheel_blue;
    logic                         load_out;

    rpg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({n_idx, rpg_pkg::COLOR_W'(0)}),
        .i_divisor  (r_span),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // only the low byte of the quotient matters after the mod 256
    assign hue_pos = div_quot + r_step[rpg_pkg::COLOR_W-1:0];

    rpg_wheel u_wheel (
        .i_pos   (hue_pos),
        .o_red   (wheel_red),
        .o_green (wheel_green),
        .o_blue  (wheel_blue)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpg_pkg::ST_IDLE;
            r_span      <= rpg_pkg::SPAN_RESET;
            r_step      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_span <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_idx   <= r_idx;
            r_red       <= wheel_red;
            r_green     <= wheel_green;
            r_blue      <= wheel_blue;
            r_frame_end <= (r_idx == LastIdx);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        div_start   = 1'b0;
        load_out    = 1'b0;
        i_in.ready  = 1'b0;
        step_inc    = r_step + 1'b1;

        case (r_state)
            rpg_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid && i_in.frame_tick) begin
                    n_step    = (step_inc == rpg_pkg::STEP_WRAP) ? '0 : step_inc;
                    n_idx     = '0;
                    div_start = 1'b1;
                    n_state   = rpg_pkg::ST_DIV;
                end
            end
            rpg_pkg::ST_DIV: begin
                if (div_done) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = rpg_pkg::ST_EMIT;
                end
            end
            rpg_pkg::ST_EMIT: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    if (r_idx == LastIdx) begin
                        n_state = rpg_pkg::ST_IDLE;
                    end else begin
                        n_idx     = r_idx + 1'b1;
                        div_start = 1'b1;
                        n_state   = rpg_pkg::ST_DIV;
                    end
                end
            end
            default: begin
                n_state = rpg_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.led_index = r_out_idx;
    assign o_out.red       = r_red;
    assign o_out.green     = r_green;
    assign o_out.blue      = r_blue;
    assign o_out.frame_end = r_frame_end;

endmodule

`default_nettype wire
